// File: hdl/adar_pkg.sv
package adar_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int SLOT_W      = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Action codes on the input word.
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REVERSE = 2'd2;

    // Status codes on the result words.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Datapath micro-operations.
    typedef enum logic [3:0] {
        U_NOP,
        U_IDLE,
        U_SCAN_INIT,
        U_SCAN,
        U_SHIFT_INIT,
        U_SHIFT,
        U_DEC,
        U_APPEND,
        U_REV_INIT,
        U_REV_B,
        U_REV_C,
        U_REV_D,
        U_OUT_INIT,
        U_OUT
    } uop_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_ACT_DEL,
        C_ACT_APP,
        C_ACT_REV,
        C_EMPTY,
        C_SCAN_MORE,
        C_SHIFT_MORE,
        C_FEW,
        C_REV_MORE,
        C_OUT_DONE
    } cond_t;

    // Program steps.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP_DEL,
        S_DISP_APP,
        S_DISP_REV,
        S_SCAN_INIT,
        S_SCAN,
        S_SHIFT_INIT,
        S_SHIFT,
        S_DEC,
        S_APPEND,
        S_REV_INIT,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_OUT_INIT,
        S_OUT
    } step_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t jmp;   // next step when the condition holds
        step_t nxt;   // next step otherwise
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic act_del;
        logic act_app;
        logic act_rev;
        logic empty;
        logic scan_more;
        logic shift_more;
        logic few;
        logic rev_more;
        logic out_done;
    } flags_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        unique case (s)
            S_IDLE:       w = '{U_IDLE,       C_IN_VALID,   S_DISP_DEL,   S_IDLE};
            S_DISP_DEL:   w = '{U_NOP,        C_ACT_DEL,    S_SCAN_INIT,  S_DISP_APP};
            S_DISP_APP:   w = '{U_NOP,        C_ACT_APP,    S_APPEND,     S_DISP_REV};
            S_DISP_REV:   w = '{U_NOP,        C_ACT_REV,    S_REV_INIT,   S_OUT_INIT};
            S_SCAN_INIT:  w = '{U_SCAN_INIT,  C_EMPTY,      S_OUT_INIT,   S_SCAN};
            S_SCAN:       w = '{U_SCAN,       C_SCAN_MORE,  S_SCAN,       S_SHIFT_INIT};
            S_SHIFT_INIT: w = '{U_SHIFT_INIT, C_ALWAYS,     S_SHIFT,      S_SHIFT};
            S_SHIFT:      w = '{U_SHIFT,      C_SHIFT_MORE, S_SHIFT,      S_DEC};
            S_DEC:        w = '{U_DEC,        C_ALWAYS,     S_OUT_INIT,   S_OUT_INIT};
            S_APPEND:     w = '{U_APPEND,     C_ALWAYS,     S_OUT_INIT,   S_OUT_INIT};
            S_REV_INIT:   w = '{U_REV_INIT,   C_FEW,        S_OUT_INIT,   S_REV_B};
            S_REV_B:      w = '{U_REV_B,      C_NEVER,      S_REV_C,      S_REV_C};
            S_REV_C:      w = '{U_REV_C,      C_NEVER,      S_REV_D,      S_REV_D};
            S_REV_D:      w = '{U_REV_D,      C_REV_MORE,   S_REV_B,      S_OUT_INIT};
            S_OUT_INIT:   w = '{U_OUT_INIT,   C_NEVER,      S_OUT,        S_OUT};
            S_OUT:        w = '{U_OUT,        C_OUT_DONE,   S_IDLE,       S_OUT};
            default:      w = '{U_NOP,        C_ALWAYS,     S_IDLE,       S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/adar_useq.sv
// Step counter and control store; picks the next step from the jump condition.
module adar_useq
(
    input  logic              clk,
    input  logic              rst_n,
    input  adar_pkg::flags_t  flags,
    output adar_pkg::ctrl_t   ctrl
);

    adar_pkg::step_t step_reg;
    adar_pkg::step_t step_next;
    logic            cond_hit;

    assign ctrl = adar_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            adar_pkg::C_NEVER:      cond_hit = 1'b0;
            adar_pkg::C_ALWAYS:     cond_hit = 1'b1;
            adar_pkg::C_IN_VALID:   cond_hit = flags.in_valid;
            adar_pkg::C_ACT_DEL:    cond_hit = flags.act_del;
            adar_pkg::C_ACT_APP:    cond_hit = flags.act_app;
            adar_pkg::C_ACT_REV:    cond_hit = flags.act_rev;
            adar_pkg::C_EMPTY:      cond_hit = flags.empty;
            adar_pkg::C_SCAN_MORE:  cond_hit = flags.scan_more;
            adar_pkg::C_SHIFT_MORE: cond_hit = flags.shift_more;
            adar_pkg::C_FEW:        cond_hit = flags.few;
            adar_pkg::C_REV_MORE:   cond_hit = flags.rev_more;
            adar_pkg::C_OUT_DONE:   cond_hit = flags.out_done;
            default:                cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? ctrl.jmp : ctrl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= adar_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: hdl/adar_datapath.sv
// List store, scan and pointer registers, and the output word register.
module adar_datapath
#(
    parameter int DEPTH = adar_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  adar_pkg::ctrl_t                     ctrl,
    output adar_pkg::flags_t                    flags,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [adar_pkg::ACTION_W-1:0]       in_action,
    input  logic signed [adar_pkg::VALUE_W-1:0] in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [adar_pkg::STATUS_W-1:0]       out_status,
    output logic [adar_pkg::FILL_W-1:0]         out_fill_count,
    output logic [adar_pkg::SLOT_W-1:0]         out_slot_index,
    output logic signed [adar_pkg::VALUE_W-1:0] out_slot_value,
    output logic                                out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int VW = adar_pkg::VALUE_W;

    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    logic [adar_pkg::ACTION_W-1:0] action_reg, action_next;
    logic signed [VW-1:0]          value_reg, value_next;
    logic [adar_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]                 i_reg, i_next;
    logic [CW-1:0]                 j_reg, j_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic signed [VW-1:0]          best_reg, best_next;
    logic signed [VW-1:0]          tmp_reg, tmp_next;

    logic [adar_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic [adar_pkg::FILL_W-1:0]   ofill_reg, ofill_next;
    logic [adar_pkg::SLOT_W-1:0]   oidx_reg, oidx_next;
    logic signed [VW-1:0]          oval_reg, oval_next;
    logic                          olast_reg, olast_next;

    logic [PW-1:0]        rd_pos;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [CW-1:0]        wr_ptr;
    logic signed [VW-1:0] wr_data;

    logic [PW-1:0] i_ext, i_p1, i_p2, j_ext, cnt_ext, pos_p1;
    logic [CW-1:0] i_m1;
    logic          advance;
    logic          at_end;

    assign i_ext   = {1'b0, i_reg};
    assign j_ext   = {1'b0, j_reg};
    assign cnt_ext = {1'b0, count_reg};
    assign i_p1    = i_ext + PW'(1);
    assign i_p2    = i_ext + PW'(2);
    assign pos_p1  = PW'(pos_reg) + PW'(1);
    assign i_m1    = i_reg - CW'(1);
    assign advance = !out_valid_reg || out_ready;
    assign at_end  = (i_reg == CW'(DEPTH - 1));

    assign in_ready = (ctrl.uop == adar_pkg::U_IDLE);

    always_comb
    begin
        flags.in_valid   = in_valid;
        flags.act_del    = (action_reg == adar_pkg::ACT_DELETE);
        flags.act_app    = (action_reg == adar_pkg::ACT_APPEND);
        flags.act_rev    = (action_reg == adar_pkg::ACT_REVERSE);
        flags.empty      = (count_reg == '0);
        flags.scan_more  = (i_p1 < cnt_ext);
        flags.shift_more = (i_reg < count_reg);
        flags.few        = (count_reg < CW'(2));
        flags.rev_more   = (i_p2 < j_ext);
        flags.out_done   = advance && at_end;
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = (out_valid_reg && !out_ready);
        action_next    = action_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        tmp_next       = tmp_reg;
        ost_next       = ost_reg;
        ofill_next     = ofill_reg;
        oidx_next      = oidx_reg;
        oval_next      = oval_reg;
        olast_next     = olast_reg;
        rd_pos         = i_ext;
        wr_en          = 1'b0;
        wr_ptr         = i_reg;
        wr_data        = rdata_reg;

        unique case (ctrl.uop)
            adar_pkg::U_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = in_action;
                    value_next  = in_value;
                    status_next = adar_pkg::ST_DONE;
                end
            end
            adar_pkg::U_SCAN_INIT:
            begin
                i_next    = '0;
                pos_next  = '0;
                best_next = adar_pkg::VALUE_MIN;
                rd_pos    = '0;
                if (count_reg == '0)
                begin
                    status_next = adar_pkg::ST_EMPTY;
                end
            end
            adar_pkg::U_SCAN:
            begin
                // Strictly greater keeps the first of equal maxima.
                if (rdata_reg > best_reg)
                begin
                    best_next = rdata_reg;
                    pos_next  = i_reg[AW-1:0];
                end
                i_next = i_p1[CW-1:0];
                rd_pos = i_p1;
            end
            adar_pkg::U_SHIFT_INIT:
            begin
                i_next = pos_p1[CW-1:0];
                rd_pos = pos_p1;
            end
            adar_pkg::U_SHIFT:
            begin
                if (i_reg < count_reg)
                begin
                    wr_en   = 1'b1;
                    wr_ptr  = i_m1;
                    wr_data = rdata_reg;
                    i_next  = i_p1[CW-1:0];
                    rd_pos  = i_p1;
                end
            end
            adar_pkg::U_DEC:
            begin
                count_next = count_reg - CW'(1);
            end
            adar_pkg::U_APPEND:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    status_next = adar_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_ptr     = count_reg;
                    wr_data    = value_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            adar_pkg::U_REV_INIT:
            begin
                i_next = '0;
                j_next = count_reg - CW'(1);
                rd_pos = '0;
            end
            adar_pkg::U_REV_B:
            begin
                tmp_next = rdata_reg;
                rd_pos   = j_ext;
            end
            adar_pkg::U_REV_C:
            begin
                wr_en   = 1'b1;
                wr_ptr  = i_reg;
                wr_data = rdata_reg;
            end
            adar_pkg::U_REV_D:
            begin
                wr_en   = 1'b1;
                wr_ptr  = j_reg;
                wr_data = tmp_reg;
                i_next  = i_p1[CW-1:0];
                j_next  = j_reg - CW'(1);
                rd_pos  = i_p1;
            end
            adar_pkg::U_OUT_INIT:
            begin
                i_next = '0;
                rd_pos = '0;
            end
            adar_pkg::U_OUT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = status_reg;
                    ofill_next     = adar_pkg::FILL_W'(count_reg);
                    oidx_next      = adar_pkg::SLOT_W'(i_reg);
                    // Slots past the fill count always read as zero.
                    oval_next      = (i_reg >= count_reg) ? '0 : rdata_reg;
                    olast_next     = at_end;
                    i_next         = i_p1[CW-1:0];
                    rd_pos         = i_p1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = (rd_pos >= PW'(DEPTH)) ? '0 : rd_pos[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        pos_reg    <= pos_next;
        best_reg   <= best_next;
        tmp_reg    <= tmp_next;
        ost_reg    <= ost_next;
        ofill_reg  <= ofill_next;
        oidx_reg   <= oidx_next;
        oval_reg   <= oval_next;
        olast_reg  <= olast_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = ost_reg;
    assign out_fill_count = ofill_reg;
    assign out_slot_index = oidx_reg;
    assign out_slot_value = oval_reg;
    assign out_last       = olast_reg;

endmodule

// File: hdl/array_delete_max_append_reverse_unit.sv
// List of up to DEPTH signed 32-bit values with a fill count, run by a small
// microcoded sequencer over a single-port-read store. Each input word carries
// an action (delete the first largest entry, append a value, or reverse the
// filled entries; code 3 changes nothing) and, in response, the block emits a
// run of DEPTH result words, one per slot in order, each with the status, the
// fill count, the slot index and the slot content, tlast on the final slot.
// Each input word first passes the dispatch steps, which test for delete,
// then append, then reverse; delete then scans for the first largest entry
// and shifts the later entries down, append writes the value after the last
// entry unless the list is full, reverse swaps pairs from both ends inward,
// and the run follows, held whenever the output side stalls; the single
// memory read port with its registered read data shapes these loops. A new input
// word is taken once the last result word of a run sits in the output
// register, so that word and the next operation overlap. Reset clears the
// fill count, the output valid flag and the step, not the store: slots past
// the count always read as zero, so no clearing pass is needed.
module array_delete_max_append_reverse_unit
#(
    parameter int DEPTH = adar_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input words.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] action, [33:2] value, [39:34] zero
    input  logic [adar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Result words.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] status, [6:2] fill_count, [10:7] slot_index,
    // [42:11] slot_value, [47:43] zero
    output logic [adar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int AC_W = adar_pkg::ACTION_W;
    localparam int VL_W = adar_pkg::VALUE_W;
    localparam int ST_W = adar_pkg::STATUS_W;
    localparam int FL_W = adar_pkg::FILL_W;
    localparam int SL_W = adar_pkg::SLOT_W;
    localparam int OUT_USED = ST_W + FL_W + SL_W + VL_W;

    adar_pkg::ctrl_t  ctrl;
    adar_pkg::flags_t flags;

    logic [AC_W-1:0]        in_action;
    logic signed [VL_W-1:0] in_value;
    logic [ST_W-1:0]        out_status;
    logic [FL_W-1:0]        out_fill_count;
    logic [SL_W-1:0]        out_slot_index;
    logic signed [VL_W-1:0] out_slot_value;

    // Input word unpacking; the pad bits above value are ignored.
    assign in_action = s_axis_tdata[AC_W-1:0];
    assign in_value  = s_axis_tdata[AC_W+VL_W-1:AC_W];

    adar_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    adar_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .flags          (flags),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_action      (in_action),
        .in_value       (in_value),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (out_status),
        .out_fill_count (out_fill_count),
        .out_slot_index (out_slot_index),
        .out_slot_value (out_slot_value),
        .out_last       (m_axis_tlast)
    );

    // Result word packing, status in the lowest bits.
    assign m_axis_tdata = {{(adar_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                           out_slot_value, out_slot_index, out_fill_count, out_status};

endmodule

// File: hdl/adar_checker.sv
// Port-level checks for the list unit.
module adar_checker
#(
    parameter int DEPTH = adar_pkg::DEPTH_DEF
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [adar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    localparam logic [adar_pkg::FILL_W-1:0] FULL_FILL = adar_pkg::FILL_W'(DEPTH);
    localparam logic [adar_pkg::SLOT_W-1:0] LAST_SLOT = adar_pkg::SLOT_W'(DEPTH - 1);

    logic [adar_pkg::STATUS_W-1:0] o_status;
    logic [adar_pkg::FILL_W-1:0]   o_fill;
    logic [adar_pkg::SLOT_W-1:0]   o_index;

    assign o_status = m_axis_tdata[1:0];
    assign o_fill   = m_axis_tdata[6:2];
    assign o_index  = m_axis_tdata[10:7];

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // The block works on one input word at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_status == adar_pkg::ST_EMPTY |-> o_fill == '0)
        else $error("empty status with a nonzero fill count");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_status == adar_pkg::ST_FULL |-> o_fill == FULL_FILL)
        else $error("full status while the list is not full");

    // The final slot of a run carries the last index.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (DEPTH <= 16) |-> m_axis_tlast == (o_index == LAST_SLOT))
        else $error("tlast does not match the last slot index");

endmodule

bind array_delete_max_append_reverse_unit adar_checker
#(
    .DEPTH (DEPTH)
)
u_adar_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
